@@ design/sgks_pkg.sv @@
// shared types, constants and state codes for the sorted group-by-key sum core
package sgks_pkg;

  localparam int KEY_W   = 32;
  localparam int AMT_W   = 40;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 32;
  localparam int FEE_W   = 20;
  localparam int FTOT_W  = 52;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [KEY_W-1:0]        bank_id;
    logic signed [AMT_W-1:0] amount_cents;
    logic                    last_item;
  } sgks_in_t;

  typedef struct packed {
    logic [KEY_W-1:0]        group_key;
    logic signed [SUM_W-1:0] total_cents;
    logic [CNT_W-1:0]        group_count;
    logic [FTOT_W-1:0]       fee_total;
    logic                    table_overflow;
    logic                    last_result;
  } sgks_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_MUL,
    ST_EMIT
  } sgks_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture accepted transfer
    logic search_clr;  // reset search index
    logic search_step; // compare one entry, advance
    logic do_update;   // write hit entry or insert
    logic scan_start;  // begin a min-above-threshold scan
    logic scan_step;   // compare one entry
    logic fetch;       // read chosen entry
    logic mul;         // register fee product
    logic emit_done;   // result transferred
  } sgks_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_end;  // hit found or all entries checked
    logic scan_end;    // all entries compared
    logic scan_found;  // an entry above threshold exists
    logic is_last;     // captured item closes the set
  } sgks_sts_t;

endpackage

@@ design/sgks_datapath.sv @@
// table memories, search, ordered scan and result formation
module sgks_datapath
  import sgks_pkg::*;
#(
  parameter int MAX_GROUPS = 64,
  parameter int IDX_W      = $clog2(MAX_GROUPS),
  parameter int USED_W     = $clog2(MAX_GROUPS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sgks_cmd_t        cmd,
  output sgks_sts_t        sts,
  input  sgks_in_t         in_item,
  input  logic [FEE_W-1:0] fee,
  output sgks_out_t        result
);

  logic [KEY_W-1:0]        key_mem [MAX_GROUPS];
  logic signed [SUM_W-1:0] sum_mem [MAX_GROUPS];
  logic [CNT_W-1:0]        cnt_mem [MAX_GROUPS];

  sgks_in_t                item_r;
  logic [USED_W-1:0]       used_r, used_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [USED_W-1:0]       idx_r, idx_nxt;
  logic                    hit_r, hit_nxt;
  logic [IDX_W-1:0]        hit_idx_r, hit_idx_nxt;

  logic [KEY_W-1:0]        rd_key_r;
  logic signed [SUM_W-1:0] rd_sum_r;
  logic [CNT_W-1:0]        rd_cnt_r;
  logic                    srch_vld_r;
  logic                    scan_vld_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic                    hit_now;

  // ordered scan: threshold is the last emitted key
  logic [KEY_W-1:0]        thr_r, thr_nxt;
  logic                    thr_vld_r, thr_vld_nxt;
  logic [KEY_W-1:0]        best_key_r, best_key_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic                    best_vld_r, best_vld_nxt;
  logic [USED_W-1:0]       emitted_r, emitted_nxt;

  logic [FTOT_W-1:0]       fee_r;
  logic [KEY_W-1:0]        out_key_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [CNT_W-1:0]        out_cnt_r;

  logic [IDX_W-1:0]        idx_lo;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [KEY_W-1:0]        wr_key;
  logic signed [SUM_W-1:0] wr_sum;
  logic [CNT_W-1:0]        wr_cnt;

  assign idx_lo = idx_r[IDX_W-1:0];

  // one registered read port shared by search, scan and fetch
  always_comb begin
    rd_en   = cmd.search_step || cmd.scan_step || cmd.fetch;
    rd_addr = cmd.fetch ? best_idx_r : idx_lo;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_sum_r <= sum_mem[rd_addr];
      rd_cnt_r <= cnt_mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
  end

  // which kind of read the registered data came from
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_vld_r <= 1'b0;
      scan_vld_r <= 1'b0;
    end else begin
      srch_vld_r <= cmd.search_step;
      scan_vld_r <= cmd.scan_step;
    end
  end

  // key match on the entry read last cycle, stops the search so the data holds
  assign hit_now = srch_vld_r && !hit_r && (rd_key_r == item_r.bank_id);

  always_comb begin
    sum_wide = {rd_sum_r[SUM_W-1], rd_sum_r}
             + {{(SUM_W+1-AMT_W){item_r.amount_cents[AMT_W-1]}}, item_r.amount_cents};
    if (sum_wide > $signed({1'b0, SUM_MAX}))      sum_sat = SUM_MAX;
    else if (sum_wide < $signed({1'b1, SUM_MIN})) sum_sat = SUM_MIN;
    else                                          sum_sat = sum_wide[SUM_W-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_key  = item_r.bank_id;
    wr_sum  = sum_sat;
    wr_cnt  = (rd_cnt_r == '1) ? rd_cnt_r : rd_cnt_r + CNT_W'(1);
    if (cmd.do_update) begin
      if (hit_r) begin
        wr_en = 1'b1;
      end else if (used_r < USED_W'(MAX_GROUPS)) begin
        wr_en   = 1'b1;
        wr_addr = used_r[IDX_W-1:0];
        wr_sum  = {{(SUM_W-AMT_W){item_r.amount_cents[AMT_W-1]}}, item_r.amount_cents};
        wr_cnt  = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      sum_mem[wr_addr] <= wr_sum;
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_item;
  end

  // search, insert and ordered-scan bookkeeping
  always_comb begin
    used_nxt     = used_r;
    ovf_nxt      = ovf_r;
    idx_nxt      = idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    thr_nxt      = thr_r;
    thr_vld_nxt  = thr_vld_r;
    best_key_nxt = best_key_r;
    best_idx_nxt = best_idx_r;
    best_vld_nxt = best_vld_r;
    emitted_nxt  = emitted_r;

    if (cmd.search_clr) begin
      idx_nxt = '0;
      hit_nxt = 1'b0;
    end
    if (cmd.search_step) idx_nxt = idx_r + USED_W'(1);
    if (hit_now) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = rd_idx_r;
    end
    if (cmd.do_update) begin
      if (!hit_r) begin
        if (used_r < USED_W'(MAX_GROUPS)) used_nxt = used_r + USED_W'(1);
        else                              ovf_nxt  = 1'b1;
      end
    end

    if (cmd.scan_start) begin
      idx_nxt      = '0;
      best_vld_nxt = 1'b0;
    end
    if (cmd.scan_step) idx_nxt = idx_r + USED_W'(1);
    if (scan_vld_r) begin
      if ((!thr_vld_r || rd_key_r > thr_r)
          && (!best_vld_r || rd_key_r < best_key_r)) begin
        best_vld_nxt = 1'b1;
        best_key_nxt = rd_key_r;
        best_idx_nxt = rd_idx_r;
      end
    end

    if (cmd.emit_done) begin
      thr_nxt     = best_key_r;
      thr_vld_nxt = 1'b1;
      emitted_nxt = emitted_r + USED_W'(1);
      if (emitted_r + USED_W'(1) == used_r) begin
        used_nxt    = '0;
        ovf_nxt     = 1'b0;
        thr_vld_nxt = 1'b0;
        emitted_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      ovf_r      <= 1'b0;
      idx_r      <= '0;
      hit_r      <= 1'b0;
      thr_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      emitted_r  <= '0;
    end else begin
      used_r     <= used_nxt;
      ovf_r      <= ovf_nxt;
      idx_r      <= idx_nxt;
      hit_r      <= hit_nxt;
      thr_vld_r  <= thr_vld_nxt;
      best_vld_r <= best_vld_nxt;
      emitted_r  <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    thr_r      <= thr_nxt;
    best_key_r <= best_key_nxt;
    best_idx_r <= best_idx_nxt;
  end

  // fee product registered before the result is shown
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      fee_r     <= FTOT_W'(rd_cnt_r) * FTOT_W'(fee);
      out_key_r <= rd_key_r;
      out_sum_r <= rd_sum_r;
      out_cnt_r <= rd_cnt_r;
    end
  end

  always_comb begin
    sts.search_end = hit_r || hit_now || (idx_r >= used_r);
    sts.scan_end   = (idx_r >= used_r);
    sts.scan_found = best_vld_r;
    sts.is_last    = item_r.last_item;

    result.group_key      = out_key_r;
    result.total_cents    = out_sum_r;
    result.group_count    = out_cnt_r;
    result.fee_total      = fee_r;
    result.table_overflow = ovf_r;
    result.last_result    = (emitted_r + USED_W'(1) == used_r);
  end

endmodule

@@ design/sgks_ctrl.sv @@
// controller state machine for load, search, update and ordered emit
module sgks_ctrl
  import sgks_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  sgks_sts_t   sts,
  output sgks_cmd_t   cmd,
  output sgks_state_t state
);

  sgks_state_t state_r, state_nxt;
  logic        last_r, last_nxt;

  assign state = state_r;

  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_SEARCH;
      ST_SEARCH:     if (sts.search_end) state_nxt = ST_UPDATE;
      ST_UPDATE:     state_nxt = sts.is_last ? ST_SCAN : ST_IDLE;
      ST_SCAN:       if (sts.scan_end) state_nxt = ST_SCAN_WAIT;
      ST_SCAN_WAIT:  state_nxt = sts.scan_found ? ST_FETCH : ST_IDLE;
      ST_FETCH:      state_nxt = ST_FETCH_WAIT;
      ST_FETCH_WAIT: state_nxt = ST_MUL;
      ST_MUL:        state_nxt = ST_EMIT;
      ST_EMIT:       if (!out_stall) state_nxt = last_r ? ST_IDLE : ST_SCAN;
      default:       state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_SCAN_WAIT) last_nxt = 1'b0;
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_item  = in_valid;
        cmd.search_clr = in_valid;
      end
      ST_SEARCH:     cmd.search_step = !sts.search_end;
      ST_UPDATE: begin
        cmd.do_update  = 1'b1;
        cmd.scan_start = sts.is_last;
      end
      ST_SCAN:       cmd.scan_step = !sts.scan_end;
      ST_FETCH:      cmd.fetch = 1'b1;
      ST_MUL:        cmd.mul = 1'b1;
      ST_EMIT: begin
        out_valid      = 1'b1;
        cmd.emit_done  = !out_stall;
        cmd.scan_start = !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ design/sorted_group_by_key_sum_core.sv @@
// top level of the sorted group-by-key sum core
// Accepts transactions (bank key, signed 40-bit cents amount, last flag) and
// folds them into a table of up to MAX_GROUPS groups, each with a saturating
// 48-bit sum and a saturating 32-bit count. Each transaction is accepted,
// then a key search reads one stored entry per cycle through a single
// memory read port, stopping early on a hit, and then the update or insert
// is written. Keys that find no room set the overflow flag carried on every
// result. After the transfer marked last, groups are emitted in ascending
// key order; each emit rescans the table for the smallest key above the
// previous one. The fee is count times the configured per-transaction fee,
// registered before output. No input is accepted during the emit phase.
// Write the fee only while idle.
module sorted_group_by_key_sum_core
  import sgks_pkg::*;
#(
  parameter int MAX_GROUPS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sgks_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sgks_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [FEE_W-1:0] cfg_data
);

  sgks_cmd_t        cmd;
  sgks_sts_t        sts;
  sgks_state_t      state;
  logic [FEE_W-1:0] fee_r;

  // fee register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n)         fee_r <= '0;
    else if (cfg_valid) fee_r <= cfg_data;
  end

  sgks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  sgks_datapath #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_data),
    .fee     (fee_r),
    .result  (out_data)
  );

  // results appear only from the emit state
  a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state == ST_EMIT) else $error("result outside emit");

  // no input transfer while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during emit");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data)) else $error("result changed");

endmodule
